/* sv/rrts_pkg.sv */
package rrts_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TAG_W     = 16;
  localparam int RETRIES_W = 8;
  localparam int TIMEOUT_W = 16;
  localparam int ATTEMPT_W = RETRIES_W + 1;
  localparam int ENTRY_W   = TAG_W + RETRIES_W + TIMEOUT_W + 1;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_REPLY  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EVT_SEND    = 3'd0,
    EVT_DONE    = 3'd1,
    EVT_GAVEUP  = 3'd2,
    EVT_CANCEL  = 3'd3,
    EVT_NOTAKEN = 3'd4,
    EVT_FULL    = 3'd5
  } evt_t;

  // where the tag and polling flag of an outgoing word come from
  typedef enum logic [1:0] {
    TS_ZERO,
    TS_IN,
    TS_INFL,
    TS_RAM
  } tag_sel_t;

  // where busy_res and current_polling of an outgoing word come from
  typedef enum logic [1:0] {
    ST_CUR,
    ST_NONE,
    ST_RAMPOL
  } st_sel_t;

  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [RETRIES_W-1:0] retries;
    logic [TIMEOUT_W-1:0] timeout;
    logic                 polling;
  } entry_t;

  typedef struct packed {
    logic     latch_in;
    logic     q_write;
    logic     rd_en;
    logic     rd_next;
    logic     pop;
    logic     load;
    logic     tick_dec;
    logic     retry;
    logic     drop;
    logic     clr_attempts;
    logic     emit;
    evt_t     evt;
    tag_sel_t tag_sel;
    st_sel_t  st_sel;
    logic     last;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic reply_ok;
    logic inflight;
    logic full;
    logic q_nonempty;
    logic q_one;
    logic expire;
    logic attempts_nz;
  } dp_status_t;

endpackage

/* sv/rrts_ram.sv */
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/rrts_dp.sv */
module rrts_dp #(
  parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rrts_pkg::ctl_cmd_t                cmd_i,
  output rrts_pkg::dp_status_t              st_o,
  input  logic [1:0]                        in_cmd,
  input  logic [rrts_pkg::TAG_W-1:0]        in_req_tag,
  input  logic [rrts_pkg::RETRIES_W-1:0]    in_req_retries,
  input  logic [rrts_pkg::TIMEOUT_W-1:0]    in_req_timeout,
  input  logic                              in_req_polling,
  input  logic                              in_reply_matches,
  output logic                              out_valid,
  output logic [2:0]                        out_evt,
  output logic [rrts_pkg::TAG_W-1:0]        out_evt_tag,
  output logic                              out_evt_polling,
  output logic                              out_last,
  output logic                              out_busy_res,
  output logic                              out_current_polling
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = PW + 1;

  // latched input word
  rrts_pkg::cmd_t               cmd_r;
  rrts_pkg::entry_t             req_r;
  logic                         matches_r;

  // queue pointers
  logic [PW-1:0]                head_r, head_nxt, head_inc, tail, raddr;
  logic [CW-1:0]                count_r, count_nxt;
  logic [SW-1:0]                tail_sum;

  // in-flight request
  logic                         infl_valid_r, infl_valid_nxt;
  logic [rrts_pkg::TAG_W-1:0]   infl_tag_r, infl_tag_nxt;
  logic                         infl_pol_r, infl_pol_nxt;
  logic [rrts_pkg::TIMEOUT_W-1:0] infl_timeout_r, infl_timeout_nxt;
  logic [rrts_pkg::ATTEMPT_W-1:0] attempts_r, attempts_nxt;
  logic [rrts_pkg::TIMEOUT_W-1:0] ticks_r, ticks_nxt;

  rrts_pkg::entry_t             rd_entry;
  logic [rrts_pkg::ENTRY_W-1:0] rd_data;

  // result word
  logic                         out_valid_r;
  logic [2:0]                   out_evt_r;
  logic [rrts_pkg::TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic                         out_pol_r, out_pol_nxt;
  logic                         out_last_r;
  logic                         out_busy_r, out_busy_nxt;
  logic                         out_cp_r, out_cp_nxt;

  assign head_inc = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + PW'(1);
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : PW'(tail_sum);
  assign raddr    = cmd_i.rd_next ? head_inc : head_r;

  rrts_ram #(
    .WIDTH (rrts_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd_i.q_write),
    .waddr (tail),
    .wdata (req_r),
    .re    (cmd_i.rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign rd_entry = rrts_pkg::entry_t'(rd_data);

  always_comb begin
    head_nxt         = head_r;
    count_nxt        = count_r;
    infl_valid_nxt   = infl_valid_r;
    infl_tag_nxt     = infl_tag_r;
    infl_pol_nxt     = infl_pol_r;
    infl_timeout_nxt = infl_timeout_r;
    attempts_nxt     = attempts_r;
    ticks_nxt        = ticks_r;

    if (cmd_i.q_write) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd_i.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CW'(1);
    end

    if (cmd_i.load) begin
      // take the head and send its first attempt
      infl_valid_nxt   = 1'b1;
      infl_tag_nxt     = rd_entry.tag;
      infl_pol_nxt     = rd_entry.polling;
      infl_timeout_nxt = rd_entry.timeout;
      attempts_nxt     = rrts_pkg::ATTEMPT_W'(rd_entry.retries);
      ticks_nxt        = (rd_entry.timeout == '0) ? rrts_pkg::TIMEOUT_W'(1)
                                                  : rd_entry.timeout;
    end else if (cmd_i.retry) begin
      attempts_nxt = attempts_r - rrts_pkg::ATTEMPT_W'(1);
      ticks_nxt    = (infl_timeout_r == '0) ? rrts_pkg::TIMEOUT_W'(1) : infl_timeout_r;
    end else if (cmd_i.tick_dec) begin
      ticks_nxt = ticks_r - rrts_pkg::TIMEOUT_W'(1);
    end else if (cmd_i.drop) begin
      infl_valid_nxt = 1'b0;
      ticks_nxt      = '0;
      if (cmd_i.clr_attempts) begin
        attempts_nxt = '0;
      end
    end
  end

  always_comb begin
    case (cmd_i.tag_sel)
      rrts_pkg::TS_IN: begin
        out_tag_nxt = req_r.tag;
        out_pol_nxt = req_r.polling;
      end
      rrts_pkg::TS_INFL: begin
        out_tag_nxt = infl_tag_r;
        out_pol_nxt = infl_pol_r;
      end
      rrts_pkg::TS_RAM: begin
        out_tag_nxt = rd_entry.tag;
        out_pol_nxt = rd_entry.polling;
      end
      default: begin
        out_tag_nxt = '0;
        out_pol_nxt = 1'b0;
      end
    endcase

    case (cmd_i.st_sel)
      rrts_pkg::ST_NONE: begin
        out_busy_nxt = 1'b0;
        out_cp_nxt   = 1'b0;
      end
      rrts_pkg::ST_RAMPOL: begin
        out_busy_nxt = 1'b1;
        out_cp_nxt   = rd_entry.polling;
      end
      default: begin
        out_busy_nxt = infl_valid_r || (count_r != '0);
        out_cp_nxt   = infl_valid_r && infl_pol_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r         <= '0;
      count_r        <= '0;
      infl_valid_r   <= 1'b0;
      infl_tag_r     <= '0;
      infl_pol_r     <= 1'b0;
      infl_timeout_r <= '0;
      attempts_r     <= '0;
      ticks_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      head_r         <= head_nxt;
      count_r        <= count_nxt;
      infl_valid_r   <= infl_valid_nxt;
      infl_tag_r     <= infl_tag_nxt;
      infl_pol_r     <= infl_pol_nxt;
      infl_timeout_r <= infl_timeout_nxt;
      attempts_r     <= attempts_nxt;
      ticks_r        <= ticks_nxt;
      out_valid_r    <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch_in) begin
      cmd_r       <= rrts_pkg::cmd_t'(in_cmd);
      req_r       <= {in_req_tag, in_req_retries, in_req_timeout, in_req_polling};
      matches_r   <= in_reply_matches;
    end
    if (cmd_i.emit) begin
      out_evt_r   <= cmd_i.evt;
      out_tag_r   <= out_tag_nxt;
      out_pol_r   <= out_pol_nxt;
      out_last_r  <= cmd_i.last;
      out_busy_r  <= out_busy_nxt;
      out_cp_r    <= out_cp_nxt;
    end
  end

  assign st_o.cmd         = cmd_r;
  assign st_o.reply_ok    = matches_r;
  assign st_o.inflight    = infl_valid_r;
  assign st_o.full        = (count_r == CW'(QUEUE_DEPTH));
  assign st_o.q_nonempty  = (count_r != '0);
  assign st_o.q_one       = (count_r == CW'(1));
  assign st_o.expire      = (ticks_r <= rrts_pkg::TIMEOUT_W'(1));
  assign st_o.attempts_nz = (attempts_r != '0);

  assign out_valid           = out_valid_r;
  assign out_evt             = out_evt_r;
  assign out_evt_tag         = out_tag_r;
  assign out_evt_polling     = out_pol_r;
  assign out_last            = out_last_r;
  assign out_busy_res        = out_busy_r;
  assign out_current_polling = out_cp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.q_write |-> !st_o.full)
    else $error("write into full queue");

  a_inflight_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    infl_valid_r |-> (ticks_r != '0))
    else $error("in-flight request without timer");

  a_cancel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_evt_r == rrts_pkg::EVT_CANCEL)) |-> (!out_busy_r && !out_cp_r))
    else $error("cancel word reports busy");

endmodule

/* sv/rrts_ctrl.sv */
module rrts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rrts_pkg::dp_status_t st_i,
  output rrts_pkg::ctl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_LOAD,
    S_SEND,
    S_CQ
  } state_t;

  state_t          state_r, state_nxt;
  logic            fin_pend_r, fin_pend_nxt;
  rrts_pkg::evt_t  fin_evt_r, fin_evt_nxt;
  logic            finish;
  rrts_pkg::evt_t  finish_evt;
  rrts_pkg::ctl_cmd_t c;

  always_comb begin
    state_nxt    = state_r;
    fin_pend_nxt = fin_pend_r;
    fin_evt_nxt  = fin_evt_r;
    finish       = 1'b0;
    finish_evt   = rrts_pkg::EVT_DONE;
    c            = '0;
    c.evt        = rrts_pkg::EVT_SEND;
    c.tag_sel    = rrts_pkg::TS_ZERO;
    c.st_sel     = rrts_pkg::ST_CUR;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          c.latch_in = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (st_i.cmd)
          rrts_pkg::CMD_ENQ: begin
            if (st_i.full) begin
              c.emit    = 1'b1;
              c.evt     = rrts_pkg::EVT_FULL;
              c.tag_sel = rrts_pkg::TS_IN;
              c.last    = 1'b1;
            end else begin
              c.q_write = 1'b1;
              if (!st_i.inflight) begin
                fin_pend_nxt = 1'b0;
                state_nxt    = S_RD;
              end
            end
          end
          rrts_pkg::CMD_REPLY: begin
            if (!st_i.inflight) begin
              c.emit = 1'b1;
              c.evt  = rrts_pkg::EVT_NOTAKEN;
              c.last = 1'b1;
            end else if (!st_i.reply_ok) begin
              c.emit    = 1'b1;
              c.evt     = rrts_pkg::EVT_NOTAKEN;
              c.tag_sel = rrts_pkg::TS_INFL;
              c.last    = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
          rrts_pkg::CMD_TICK: begin
            if (st_i.inflight) begin
              if (!st_i.expire) begin
                c.tick_dec = 1'b1;
              end else if (st_i.attempts_nz) begin
                c.retry   = 1'b1;
                c.emit    = 1'b1;
                c.tag_sel = rrts_pkg::TS_INFL;
                c.last    = 1'b1;
              end else begin
                finish     = 1'b1;
                finish_evt = rrts_pkg::EVT_GAVEUP;
              end
            end
          end
          rrts_pkg::CMD_CANCEL: begin
            if (st_i.inflight) begin
              c.emit         = 1'b1;
              c.evt          = rrts_pkg::EVT_CANCEL;
              c.tag_sel      = rrts_pkg::TS_INFL;
              c.st_sel       = rrts_pkg::ST_NONE;
              c.last         = !st_i.q_nonempty;
              c.drop         = 1'b1;
              c.clr_attempts = 1'b1;
            end
            if (st_i.q_nonempty) begin
              c.rd_en   = 1'b1;
              state_nxt = S_CQ;
            end
          end
          default: state_nxt = S_IDLE;
        endcase

        // complete the in-flight request; hold the word until the next
        // head is read when one is queued, since its polling flag is needed
        if (finish) begin
          c.drop = 1'b1;
          if (st_i.q_nonempty) begin
            fin_pend_nxt = 1'b1;
            fin_evt_nxt  = finish_evt;
            state_nxt    = S_RD;
          end else begin
            c.emit    = 1'b1;
            c.evt     = finish_evt;
            c.tag_sel = rrts_pkg::TS_INFL;
            c.st_sel  = rrts_pkg::ST_NONE;
            c.last    = 1'b1;
          end
        end
      end
      S_RD: begin
        c.rd_en   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (fin_pend_r) begin
          c.emit    = 1'b1;
          c.evt     = fin_evt_r;
          c.tag_sel = rrts_pkg::TS_INFL;
          c.st_sel  = rrts_pkg::ST_RAMPOL;
        end
        c.load    = 1'b1;
        c.pop     = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        c.emit    = 1'b1;
        c.tag_sel = rrts_pkg::TS_INFL;
        c.last    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CQ: begin
        // drain one queued entry per cycle, reading the next ahead
        c.emit    = 1'b1;
        c.evt     = rrts_pkg::EVT_CANCEL;
        c.tag_sel = rrts_pkg::TS_RAM;
        c.st_sel  = rrts_pkg::ST_NONE;
        c.last    = st_i.q_one;
        c.pop     = 1'b1;
        if (st_i.q_one) begin
          state_nxt = S_IDLE;
        end else begin
          c.rd_en   = 1'b1;
          c.rd_next = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fin_pend_r <= 1'b0;
      fin_evt_r  <= rrts_pkg::EVT_DONE;
    end else begin
      state_r    <= state_nxt;
      fin_pend_r <= fin_pend_nxt;
      fin_evt_r  <= fin_evt_nxt;
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign cmd_o = c;

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CQ) |-> st_i.q_nonempty)
    else $error("drain with empty queue");

  a_send_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND) |-> st_i.inflight)
    else $error("send without in-flight request");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_EXEC))
    else $error("accepted word not executed");

endmodule

/* sv/request_retry_timeout_sequencer_core.sv */
// Stop-and-wait request sequencer with retry and timeout.
// Input channel: a word is taken on a clock edge with start high and busy
// low. in_cmd selects enqueue, inbound reply (in_reply_matches), tick or
// cancel-all; the in_req_* ports carry the request for an enqueue.
// Result channel: out_valid marks each result word for exactly one cycle;
// out_last flags the final word caused by one input word. Some commands
// cause no word at all. The receiver cannot stall the block.
// Timing: an accepted word runs in S_EXEC; result words are registered.
// busy stays high in S_EXEC only, or in S_EXEC, S_RD, S_LOAD and S_SEND when
// the next queued request is started (one RAM read, load, send). Cancel
// drains the queue at one word per cycle via the registered RAM read port,
// with busy high in S_CQ until it is empty. At most one result word per cycle.
// Reset: queue empty, nothing in flight, out_valid low. The request RAM
// is not cleared; only entries already written are ever read.
module request_retry_timeout_sequencer_core #(
  parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_cmd,
  input  logic [rrts_pkg::TAG_W-1:0]     in_req_tag,
  input  logic [rrts_pkg::RETRIES_W-1:0] in_req_retries,
  input  logic [rrts_pkg::TIMEOUT_W-1:0] in_req_timeout,
  input  logic                           in_req_polling,
  input  logic                           in_reply_matches,
  output logic                           out_valid,
  output logic [2:0]                     out_evt,
  output logic [rrts_pkg::TAG_W-1:0]     out_evt_tag,
  output logic                           out_evt_polling,
  output logic                           out_last,
  output logic                           out_busy_res,
  output logic                           out_current_polling
);

  rrts_pkg::ctl_cmd_t   ctl_cmd;
  rrts_pkg::dp_status_t dp_status;

  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st_i  (dp_status),
    .cmd_o (ctl_cmd)
  );

  rrts_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_i               (ctl_cmd),
    .st_o                (dp_status),
    .in_cmd              (in_cmd),
    .in_req_tag          (in_req_tag),
    .in_req_retries      (in_req_retries),
    .in_req_timeout      (in_req_timeout),
    .in_req_polling      (in_req_polling),
    .in_reply_matches    (in_reply_matches),
    .out_valid           (out_valid),
    .out_evt             (out_evt),
    .out_evt_tag         (out_evt_tag),
    .out_evt_polling     (out_evt_polling),
    .out_last            (out_last),
    .out_busy_res        (out_busy_res),
    .out_current_polling (out_current_polling)
  );

endmodule

/* dv/request_sequencer_checker.sv */
`timescale 1ns / 1ps
module request_sequencer_checker #(
  parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     in_cmd,
  input  logic [rrts_pkg::TAG_W-1:0]     in_req_tag,
  input  logic [rrts_pkg::RETRIES_W-1:0] in_req_retries,
  input  logic [rrts_pkg::TIMEOUT_W-1:0] in_req_timeout,
  input  logic                           in_req_polling,
  input  logic                           in_reply_matches,
  input  logic                           out_valid,
  input  logic [2:0]                     out_evt,
  input  logic [rrts_pkg::TAG_W-1:0]     out_evt_tag,
  input  logic                           out_evt_polling,
  input  logic                           out_last,
  input  logic                           out_busy_res,
  input  logic                           out_current_polling,
  output int                             fail_count,
  output int                             pending_events,
  output int                             events_checked,
  output int                             refusals_seen,
  output int                             longest_drain
);

  localparam int TAG_W     = rrts_pkg::TAG_W;
  localparam int RETRIES_W = rrts_pkg::RETRIES_W;
  localparam int TIMEOUT_W = rrts_pkg::TIMEOUT_W;
  localparam int STEP_MAX  = QUEUE_DEPTH + 1;
  localparam int EXP_DEPTH = 256;

  typedef struct packed {
    rrts_pkg::evt_t   evt;
    logic [TAG_W-1:0] tag;
    logic             polling;
    logic             last;
    logic             busy_res;
    logic             cur_polling;
  } event_word_t;

  // shadow of the request queue and the in-flight request
  rrts_pkg::entry_t     req_store [QUEUE_DEPTH];
  int                   head_idx;
  int                   queued;
  logic                 infl_valid;
  logic [TAG_W-1:0]     infl_tag;
  logic                 infl_pol;
  logic [TIMEOUT_W-1:0] infl_timeout;
  int                   attempts;
  int                   ticks_left;

  // words of the current step, then the ring of words still to be seen
  event_word_t step_buf [STEP_MAX];
  int          step_n;
  event_word_t exp_ring [EXP_DEPTH];
  int          exp_wr;
  int          exp_rd;
  int          exp_cnt;
  int          n_fail;
  int          n_checked;
  int          n_refused;
  int          n_drain;

  task report_mismatch(input string what);
    n_fail++;
    if (n_fail <= 40) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  function void add_word(input rrts_pkg::evt_t evt, input logic [TAG_W-1:0] tag,
                         input logic pol);
    event_word_t w;
    w = '0;
    w.evt = evt;
    w.tag = tag;
    w.polling = pol;
    if (step_n < STEP_MAX) begin
      step_buf[step_n] = w;
      step_n++;
    end
  endfunction

  // a full ring drops the word, which then shows up as an unexpected event
  function void put_expected(input event_word_t w);
    if (exp_cnt < EXP_DEPTH) begin
      exp_ring[exp_wr] = w;
      exp_wr = (exp_wr + 1) % EXP_DEPTH;
      exp_cnt++;
    end
  endfunction

  function void send_attempt();
    if (attempts > 0) attempts--;
    add_word(rrts_pkg::EVT_SEND, infl_tag, infl_pol);
    ticks_left = (infl_timeout == 0) ? 1 : int'(infl_timeout);
  endfunction

  function void launch_next();
    rrts_pkg::entry_t e;
    if (infl_valid || queued == 0) return;
    e = req_store[head_idx];
    head_idx = (head_idx + 1) % QUEUE_DEPTH;
    queued--;
    infl_valid = 1'b1;
    infl_tag = e.tag;
    infl_pol = e.polling;
    infl_timeout = e.timeout;
    attempts = 1 + int'(e.retries);
    send_attempt();
  endfunction

  function void retire(input rrts_pkg::evt_t evt);
    add_word(evt, infl_tag, infl_pol);
    infl_valid = 1'b0;
    ticks_left = 0;
    launch_next();
  endfunction

  function void model_command(input rrts_pkg::cmd_t cmd, input logic [TAG_W-1:0] tag,
                              input logic [RETRIES_W-1:0] retries,
                              input logic [TIMEOUT_W-1:0] timeout,
                              input logic pol, input logic reply_ok);
    rrts_pkg::entry_t e;
    int     k;
    int     n;
    step_n = 0;
    case (cmd)
      rrts_pkg::CMD_ENQ: begin
        if (queued >= QUEUE_DEPTH) begin
          add_word(rrts_pkg::EVT_FULL, tag, pol);
          n_refused++;
        end else begin
          e.tag = tag;
          e.retries = retries;
          e.timeout = timeout;
          e.polling = pol;
          req_store[(head_idx + queued) % QUEUE_DEPTH] = e;
          queued++;
          launch_next();
        end
      end
      rrts_pkg::CMD_REPLY: begin
        if (!infl_valid) add_word(rrts_pkg::EVT_NOTAKEN, '0, 1'b0);
        else if (!reply_ok) add_word(rrts_pkg::EVT_NOTAKEN, infl_tag, infl_pol);
        else retire(rrts_pkg::EVT_DONE);
      end
      rrts_pkg::CMD_TICK: begin
        if (infl_valid) begin
          if (ticks_left > 0) ticks_left--;
          if (ticks_left == 0) begin
            if (attempts > 0) send_attempt();
            else retire(rrts_pkg::EVT_GAVEUP);
          end
        end
      end
      default: begin
        // drop the in-flight request, then drain the queue in order
        if (infl_valid) begin
          add_word(rrts_pkg::EVT_CANCEL, infl_tag, infl_pol);
          infl_valid = 1'b0;
          ticks_left = 0;
          attempts = 0;
        end
        while (queued > 0) begin
          add_word(rrts_pkg::EVT_CANCEL, req_store[head_idx].tag,
                   req_store[head_idx].polling);
          head_idx = (head_idx + 1) % QUEUE_DEPTH;
          queued--;
        end
        if (step_n > n_drain) n_drain = step_n;
      end
    endcase
    n = step_n;
    for (k = 0; k < n; k++) begin
      step_buf[k].last = (k == n - 1);
      step_buf[k].busy_res = infl_valid || queued > 0;
      step_buf[k].cur_polling = infl_valid && infl_pol;
      put_expected(step_buf[k]);
    end
  endfunction

  always @(posedge clk) begin : watch
    event_word_t want;
    if (!rst_n) begin
      head_idx = 0;
      queued = 0;
      infl_valid = 1'b0;
      infl_tag = '0;
      infl_pol = 1'b0;
      infl_timeout = '0;
      attempts = 0;
      ticks_left = 0;
      step_n = 0;
      exp_wr = 0;
      exp_rd = 0;
      exp_cnt = 0;
      n_fail = 0;
      n_checked = 0;
      n_refused = 0;
      n_drain = 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (exp_cnt == 0) begin
          report_mismatch($sformatf("unexpected event %0d tag %h", out_evt, out_evt_tag));
        end else begin
          want = exp_ring[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_DEPTH;
          exp_cnt--;
          n_checked++;
          if (out_evt !== want.evt)
            report_mismatch($sformatf("evt %0d, want %0d (tag %h)",
                                      out_evt, want.evt, want.tag));
          if (out_evt_tag !== want.tag)
            report_mismatch($sformatf("evt_tag %h, want %h", out_evt_tag, want.tag));
          if (out_evt_polling !== want.polling)
            report_mismatch($sformatf("evt_polling %b, want %b (tag %h)",
                                      out_evt_polling, want.polling, want.tag));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, want %b (tag %h)",
                                      out_last, want.last, want.tag));
          if (out_busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, want %b (tag %h)",
                                      out_busy_res, want.busy_res, want.tag));
          if (out_current_polling !== want.cur_polling)
            report_mismatch($sformatf("current_polling %b, want %b (tag %h)",
                                      out_current_polling, want.cur_polling, want.tag));
        end
      end else if (out_valid !== 1'b0) begin
        report_mismatch("out_valid unknown");
      end
      if (start && !busy) begin
        model_command(rrts_pkg::cmd_t'(in_cmd), in_req_tag, in_req_retries, in_req_timeout,
                      in_req_polling, in_reply_matches);
      end
    end
    pending_events <= exp_cnt;
    fail_count <= n_fail;
    events_checked <= n_checked;
    refusals_seen <= n_refused;
    longest_drain <= n_drain;
  end

endmodule

/* dv/request_retry_timeout_sequencer_core_test.sv */
`timescale 1ns / 1ps
module request_retry_timeout_sequencer_core_test;

  localparam int Q_DEPTH   = rrts_pkg::QUEUE_DEPTH_DEF;
  localparam int TAG_W     = rrts_pkg::TAG_W;
  localparam int RETRIES_W = rrts_pkg::RETRIES_W;
  localparam int TIMEOUT_W = rrts_pkg::TIMEOUT_W;

  localparam int LIMIT = 200000;
  // a full cancel emits one word per cycle after its read cycle
  localparam int SETTLE_CYCLES = Q_DEPTH + 12;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_cmd = rrts_pkg::CMD_TICK;
  logic [TAG_W-1:0]     in_req_tag = '0;
  logic [RETRIES_W-1:0] in_req_retries = '0;
  logic [TIMEOUT_W-1:0] in_req_timeout = '0;
  logic                 in_req_polling = 1'b0;
  logic                 in_reply_matches = 1'b0;
  logic                 out_valid;
  logic [2:0]           out_evt;
  logic [TAG_W-1:0]     out_evt_tag;
  logic                 out_evt_polling;
  logic                 out_last;
  logic                 out_busy_res;
  logic                 out_current_polling;

  int fail_count;
  int pending_events;
  int events_checked;
  int refusals_seen;
  int longest_drain;

  int cycle_count = 0;
  int words_sent = 0;
  int idle_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_retry_timeout_sequencer_core #(.QUEUE_DEPTH(Q_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_req_tag(in_req_tag), .in_req_retries(in_req_retries),
    .in_req_timeout(in_req_timeout), .in_req_polling(in_req_polling),
    .in_reply_matches(in_reply_matches),
    .out_valid(out_valid), .out_evt(out_evt), .out_evt_tag(out_evt_tag),
    .out_evt_polling(out_evt_polling), .out_last(out_last),
    .out_busy_res(out_busy_res), .out_current_polling(out_current_polling)
  );

  request_sequencer_checker #(.QUEUE_DEPTH(Q_DEPTH)) chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_req_tag(in_req_tag), .in_req_retries(in_req_retries),
    .in_req_timeout(in_req_timeout), .in_req_polling(in_req_polling),
    .in_reply_matches(in_reply_matches),
    .out_valid(out_valid), .out_evt(out_evt), .out_evt_tag(out_evt_tag),
    .out_evt_polling(out_evt_polling), .out_last(out_last),
    .out_busy_res(out_busy_res), .out_current_polling(out_current_polling),
    .fail_count(fail_count), .pending_events(pending_events),
    .events_checked(events_checked), .refusals_seen(refusals_seen),
    .longest_drain(longest_drain)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("run stopped after %0d cycles, %0d events outstanding",
               cycle_count, pending_events);
      $display("** request_retry_timeout_sequencer_core: FAILED **");
      $finish;
    end
  end

  // hold start high until the word is taken
  task send_word(input rrts_pkg::cmd_t cmd, input logic [TAG_W-1:0] tag,
                 input logic [RETRIES_W-1:0] retries, input logic [TIMEOUT_W-1:0] timeout,
                 input logic pol, input logic reply_ok);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_req_tag <= tag;
    in_req_retries <= retries;
    in_req_timeout <= timeout;
    in_req_polling <= pol;
    in_reply_matches <= reply_ok;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task drain_events();
    start <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
  endtask

  function automatic logic [TIMEOUT_W-1:0] pick_timeout();
    return ($urandom_range(9) == 0) ? TIMEOUT_W'($urandom) : TIMEOUT_W'($urandom_range(3));
  endfunction

  function automatic logic [RETRIES_W-1:0] pick_retries();
    return ($urandom_range(7) == 0) ? RETRIES_W'($urandom) : RETRIES_W'($urandom_range(2));
  endfunction

  task enqueue_one();
    send_word(rrts_pkg::CMD_ENQ, TAG_W'($urandom), pick_retries(), pick_timeout(),
              1'($urandom), 1'($urandom));
  endtask

  // advance time or answer the in-flight request, junk on unused fields
  task tick_or_reply();
    if ($urandom_range(99) < 60)
      send_word(rrts_pkg::CMD_TICK, TAG_W'($urandom), RETRIES_W'($urandom),
                TIMEOUT_W'($urandom), 1'($urandom), 1'($urandom));
    else
      send_word(rrts_pkg::CMD_REPLY, TAG_W'($urandom), RETRIES_W'($urandom),
                TIMEOUT_W'($urandom), 1'($urandom), $urandom_range(99) < 75);
  endtask

  task episode();
    int kind;
    int n;
    int k;
    kind = $urandom_range(99);
    if (kind < 65) begin
      n = $urandom_range(4, 1);
      for (k = 0; k < n; k++) enqueue_one();
      n = $urandom_range(8, 2);
      for (k = 0; k < n; k++) tick_or_reply();
    end else if (kind < 85) begin
      send_word(rrts_pkg::cmd_t'(2'($urandom_range(3))), TAG_W'($urandom),
                RETRIES_W'($urandom), TIMEOUT_W'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      n = $urandom_range(5);
      for (k = 0; k < n; k++) enqueue_one();
      send_word(rrts_pkg::CMD_CANCEL, TAG_W'($urandom), RETRIES_W'($urandom),
                TIMEOUT_W'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // one in flight, a full queue, one refused, then the longest cancel
  task fill_and_cancel();
    int k;
    send_word(rrts_pkg::CMD_CANCEL, '0, '0, '0, 1'b0, 1'b0);
    for (k = 0; k < Q_DEPTH + 2; k++)
      send_word(rrts_pkg::CMD_ENQ, TAG_W'($urandom), RETRIES_W'($urandom),
                16'hff00 | TIMEOUT_W'(k), 1'($urandom), 1'($urandom));
    send_word(rrts_pkg::CMD_CANCEL, '0, '0, '0, 1'b0, 1'b0);
  endtask

  initial begin
    int phase;
    int target;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 7;
    send_word(rrts_pkg::CMD_REPLY, 16'h1234, '0, '0, 1'b1, 1'b1);  // nothing in flight
    send_word(rrts_pkg::CMD_TICK, '0, '0, '0, 1'b0, 1'b0);         // idle tick
    send_word(rrts_pkg::CMD_CANCEL, '0, '0, '0, 1'b0, 1'b0);       // idle cancel
    send_word(rrts_pkg::CMD_ENQ, 16'hffff, 8'h00, 16'h0000, 1'b1, 1'b0);
    send_word(rrts_pkg::CMD_REPLY, '0, '0, '0, 1'b0, 1'b0);        // wrong reply
    send_word(rrts_pkg::CMD_TICK, '0, '0, '0, 1'b0, 1'b0);         // zero timeout expires
    send_word(rrts_pkg::CMD_ENQ, 16'h0000, 8'h01, 16'h0002, 1'b0, 1'b0);
    send_word(rrts_pkg::CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    send_word(rrts_pkg::CMD_TICK, '0, '0, '0, 1'b0, 1'b0);         // resend
    send_word(rrts_pkg::CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    send_word(rrts_pkg::CMD_TICK, '0, '0, '0, 1'b0, 1'b0);         // give up
    send_word(rrts_pkg::CMD_ENQ, 16'hffff, 8'hff, 16'hffff, 1'b1, 1'b1);
    send_word(rrts_pkg::CMD_ENQ, 16'h5a5a, 8'h00, 16'h0001, 1'b0, 1'b0);
    send_word(rrts_pkg::CMD_ENQ, 16'ha5a5, 8'h02, 16'h0003, 1'b1, 1'b0);
    send_word(rrts_pkg::CMD_REPLY, 16'hffff, 8'hff, 16'hffff, 1'b1, 1'b1); // next goes out
    send_word(rrts_pkg::CMD_CANCEL, '0, '0, '0, 1'b0, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 7 : (phase == 1) ? 73 : 0;
      target = words_sent + 24;
      if (phase == 1) fill_and_cancel();
      while (words_sent < target - 12) episode();
      drain_events();
      while (words_sent < target) episode();
    end

    drain_events();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d command words and %0d checked events in %0d cycles",
             words_sent, events_checked, cycle_count);
    $display("queue-full refusals %0d, longest cancel drain %0d events",
             refusals_seen, longest_drain);
    if (fail_count == 0) begin
      $display("** request_retry_timeout_sequencer_core: PASSED **");
    end else begin
      $display("** request_retry_timeout_sequencer_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rrts_pkg.sv
sv/rrts_ram.sv
sv/rrts_dp.sv
sv/rrts_ctrl.sv
sv/request_retry_timeout_sequencer_core.sv
dv/request_sequencer_checker.sv
dv/request_retry_timeout_sequencer_core_test.sv
